FILE: rtl/ecb_pkg.sv
// shared types and constants for the edge coverage bitmap
package ecb_pkg;

  localparam int HASH_W  = 64;
  localparam int MIX_W   = 32;
  localparam int INDEX_W = 16;
  localparam int COUNT_W = 8;
  localparam int CFG_W   = 5;

  localparam logic [MIX_W-1:0] MIX_MUL_A = 32'h7feb352d;
  localparam logic [MIX_W-1:0] MIX_MUL_B = 32'h846ca68b;

  localparam logic [CFG_W-1:0] MAP_INDEX_BITS_RST = 5'd16;

  localparam logic OPC_RECORD = 1'b0;
  localparam logic OPC_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_RESULT
  } state_e;

endpackage

FILE: rtl/ecb_in_if.sv
// input channel: one trace event or counter read per transaction
interface ecb_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [ecb_pkg::HASH_W-1:0]     mod_hash;
  logic [ecb_pkg::HASH_W-1:0]     block_offset;
  logic [ecb_pkg::INDEX_W-1:0]    read_index;

  modport source (output valid, opcode, mod_hash, block_offset, read_index, input ready);
  modport sink   (input valid, opcode, mod_hash, block_offset, read_index, output ready);
endinterface

FILE: rtl/ecb_out_if.sv
// result channel: entry index and counter value
interface ecb_out_if;
  logic                           valid;
  logic                           ready;
  logic [ecb_pkg::INDEX_W-1:0]    entry_index;
  logic [ecb_pkg::COUNT_W-1:0]    hit_count;

  modport source (output valid, entry_index, hit_count, input ready);
  modport sink   (input valid, entry_index, hit_count, output ready);
endinterface

FILE: rtl/ecb_cfg_if.sv
// configuration write channel for the map size register
interface ecb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ecb_pkg::CFG_W-1:0]      map_index_bits;

  modport source (output valid, map_index_bits, input ready);
  modport sink   (input valid, map_index_bits, output ready);
endinterface

FILE: rtl/ecb_mix.sv
// five stage pipelined 64-bit xor-shift multiply finaliser, low 32 bits out
module ecb_mix (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ecb_pkg::HASH_W-1:0]   value_i,
  output logic                         done_o,
  output logic [ecb_pkg::MIX_W-1:0]    mix_o
);

  logic [4:0]  vld_q;
  logic [63:0] x0_q;
  logic [63:0] plo_q;
  logic [31:0] phi_q;
  logic [63:0] x1x_q;
  logic [63:0] qlo_q;
  logic [15:0] qhi_q;
  logic [31:0] mix_q;

  logic [63:0] x1;
  logic [47:0] x2;

  // only the low 32 bits of the upper partial product reach the result
  assign x1 = plo_q + {phi_q, 32'h0};
  // low 48 bits suffice for the last shift-xor
  assign x2 = qlo_q[47:0] + {qhi_q, 32'h0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q  <= value_i ^ (value_i >> 16);
    plo_q <= 64'(x0_q[31:0]) * 64'(ecb_pkg::MIX_MUL_A);
    phi_q <= 32'(x0_q[63:32] * ecb_pkg::MIX_MUL_A);
    x1x_q <= x1 ^ (x1 >> 15);
    qlo_q <= 64'(x1x_q[31:0]) * 64'(ecb_pkg::MIX_MUL_B);
    qhi_q <= 16'(x1x_q[47:32] * ecb_pkg::MIX_MUL_B[15:0]);
    mix_q <= x2[31:0] ^ x2[47:16];
  end

  assign done_o = vld_q[4];
  assign mix_o  = mix_q;

endmodule

FILE: rtl/edge_coverage_bitmap_core.sv
// edge coverage bitmap: location hash, edge counter read-modify-write, counter reads
// record transaction: location hash through the five stage hash pipeline, one memory read,
//   one write-back and the output load; the next accept waits until the result is loaded
// read transaction: one memory read and the output load; one transaction is in flight at a time
// reset: clearing pass over all 2**MAP_BITS counters (one counter per cycle) before the first accept,
//   configuration writes are taken throughout; map size resets to 16, previous location to 0
module edge_coverage_bitmap_core #(
  parameter int MAP_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ecb_in_if.sink        in_i,
  ecb_out_if.source     out_o,
  ecb_cfg_if.sink       cfg_i
);

  localparam int Depth = 1 << MAP_BITS;
  localparam logic [ecb_pkg::CFG_W-1:0] MapBitsW = ecb_pkg::CFG_W'(MAP_BITS);

  // counter memory, one read and one write port, registered read data
  logic [ecb_pkg::COUNT_W-1:0] cnt_mem [Depth];
  logic [ecb_pkg::COUNT_W-1:0] mem_rd_q;
  logic                        mem_re;
  logic [MAP_BITS-1:0]         mem_raddr;
  logic                        mem_we;
  logic [MAP_BITS-1:0]         mem_waddr;
  logic [ecb_pkg::COUNT_W-1:0] mem_wdata;

  ecb_pkg::state_e state_q, state_d;

  logic [ecb_pkg::CFG_W-1:0]   cfg_q;
  logic [MAP_BITS-1:0]         clr_idx_q;
  logic [ecb_pkg::INDEX_W-1:0] prev_q;
  logic                        op_q;
  logic [MAP_BITS-1:0]         idx_q;
  logic [ecb_pkg::COUNT_W-1:0] res_count_q;
  logic                        out_valid_q, out_valid_d;
  logic [ecb_pkg::INDEX_W-1:0] out_index_q;
  logic [ecb_pkg::COUNT_W-1:0] out_count_q;

  logic [ecb_pkg::CFG_W-1:0]   eff_bits;
  logic [MAP_BITS-1:0]         mask;
  logic [MAP_BITS-1:0]         rd_idx;
  logic [MAP_BITS-1:0]         loc;
  logic [MAP_BITS-1:0]         edge_addr;
  logic [ecb_pkg::COUNT_W-1:0] upd_count;

  logic                        in_accept;
  logic                        in_ready;
  logic                        mix_start;
  logic                        mix_done;
  logic [ecb_pkg::MIX_W-1:0]   mix;
  logic [ecb_pkg::HASH_W-1:0]  mix_in;
  logic                        out_load;

  // ---------------------------------------------------------------------------
  // map size: zero acts as one, anything above MAP_BITS acts as MAP_BITS
  // ---------------------------------------------------------------------------
  always_comb begin
    eff_bits = cfg_q;
    if (cfg_q == '0) begin
      eff_bits = ecb_pkg::CFG_W'(1);
    end else if (cfg_q > MapBitsW) begin
      eff_bits = MapBitsW;
    end
  end

  assign mask = ~({MAP_BITS{1'b1}} << eff_bits);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ecb_pkg::MAP_INDEX_BITS_RST;
    end else if (cfg_i.valid) begin
      cfg_q <= cfg_i.map_index_bits;
    end
  end

  // ---------------------------------------------------------------------------
  // location hash
  // ---------------------------------------------------------------------------
  assign mix_in    = {in_i.mod_hash[ecb_pkg::HASH_W-2:0], 1'b0} ^ in_i.block_offset;
  assign in_accept = in_i.valid && in_ready;
  assign mix_start = in_accept && (in_i.opcode == ecb_pkg::OPC_RECORD);

  ecb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mix_start),
    .value_i (mix_in),
    .done_o  (mix_done),
    .mix_o   (mix)
  );

  // edge index from the new location and the stored previous one
  assign loc       = MAP_BITS'(mix) & mask;
  assign edge_addr = (loc ^ MAP_BITS'(prev_q)) & mask;
  assign rd_idx    = MAP_BITS'(in_i.read_index) & mask;
  assign upd_count = mem_rd_q + ecb_pkg::COUNT_W'(1);

  // ---------------------------------------------------------------------------
  // sequencer: one transaction in flight, so the counter write-back always
  // lands before the next read of the memory and no forwarding is needed
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ecb_pkg::ST_CLEAR: begin
        if (&clr_idx_q) state_d = ecb_pkg::ST_IDLE;
      end
      ecb_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.opcode == ecb_pkg::OPC_READ) ? ecb_pkg::ST_READ : ecb_pkg::ST_HASH;
        end
      end
      ecb_pkg::ST_HASH: begin
        if (mix_done) state_d = ecb_pkg::ST_READ;
      end
      ecb_pkg::ST_READ: begin
        state_d = ecb_pkg::ST_RESULT;
      end
      ecb_pkg::ST_RESULT: begin
        if (!out_valid_q || out_o.ready) state_d = ecb_pkg::ST_IDLE;
      end
      default: begin
        state_d = ecb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = rd_idx;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = upd_count;
    out_load  = 1'b0;
    case (state_q)
      ecb_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        mem_wdata = '0;
      end
      ecb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        mem_re   = in_i.valid && (in_i.opcode == ecb_pkg::OPC_READ);
      end
      ecb_pkg::ST_HASH: begin
        mem_re    = mix_done;
        mem_raddr = edge_addr;
      end
      ecb_pkg::ST_READ: begin
        // write back the incremented counter for a record transaction
        mem_we = (op_q == ecb_pkg::OPC_RECORD);
      end
      ecb_pkg::ST_RESULT: begin
        out_load = !out_valid_q || out_o.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ecb_pkg::ST_CLEAR;
      clr_idx_q <= '0;
      prev_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ecb_pkg::ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + MAP_BITS'(1);
      end
      if (state_q == ecb_pkg::ST_HASH && mix_done) begin
        prev_q <= ecb_pkg::INDEX_W'(loc >> 1);
      end
    end
  end

  // transaction payload held while it is worked on
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= in_i.opcode;
      idx_q <= rd_idx;
    end
    if (state_q == ecb_pkg::ST_HASH && mix_done) begin
      idx_q <= edge_addr;
    end
    if (state_q == ecb_pkg::ST_READ) begin
      res_count_q <= (op_q == ecb_pkg::OPC_READ) ? mem_rd_q : upd_count;
    end
  end

  // counter memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rd_q <= cnt_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // output register: frees the input side while a result waits
  // ---------------------------------------------------------------------------
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q <= ecb_pkg::INDEX_W'(idx_q);
      out_count_q <= res_count_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.entry_index = out_index_q;
  assign out_o.hit_count   = out_count_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the hash pipeline only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_done |-> (state_q == ecb_pkg::ST_HASH))
    else $error("hash result outside hash wait");

  // a record transaction stores its counter plus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecb_pkg::ST_READ && op_q == ecb_pkg::OPC_RECORD)
      |=> (res_count_q == ecb_pkg::COUNT_W'($past(mem_rd_q) + ecb_pkg::COUNT_W'(1))))
    else $error("counter increment mismatch");

  // no accept while the clearing pass runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecb_pkg::ST_CLEAR) |-> !in_i.ready && !out_o.valid)
    else $error("traffic during clearing pass");

endmodule

FILE: sim/tb_edge_coverage_bitmap_core.sv
// self-checking testbench for the edge coverage bitmap core
module tb_edge_coverage_bitmap_core;

  localparam int MAP_BITS     = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic                        opcode;
    logic [ecb_pkg::HASH_W-1:0]  mod_hash;
    logic [ecb_pkg::HASH_W-1:0]  block_offset;
    logic [ecb_pkg::INDEX_W-1:0] read_index;
    logic                        read_recent;  // read the edge touched last
  } trace_event_t;

  typedef struct packed {
    logic [ecb_pkg::INDEX_W-1:0] entry_index;
    logic [ecb_pkg::COUNT_W-1:0] hit_count;
  } hit_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  ecb_in_if  in_if();
  ecb_out_if out_if();
  ecb_cfg_if cfg_if();

  trace_event_t              offered = '0;
  logic                      in_valid = 1'b0;
  logic                      out_ready = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [ecb_pkg::CFG_W-1:0] cfg_bits = '0;

  assign in_if.valid        = in_valid;
  assign in_if.opcode       = offered.opcode;
  assign in_if.mod_hash     = offered.mod_hash;
  assign in_if.block_offset = offered.block_offset;
  assign in_if.read_index   = offered.read_index;
  assign out_if.ready       = out_ready;
  assign cfg_if.valid       = cfg_valid;
  assign cfg_if.map_index_bits = cfg_bits;

  edge_coverage_bitmap_core #(.MAP_BITS(MAP_BITS)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predicted state
  logic [ecb_pkg::COUNT_W-1:0] model_counts [2**MAP_BITS] = '{default: '0};
  logic [ecb_pkg::INDEX_W-1:0] model_prev_loc = '0;
  logic [ecb_pkg::CFG_W-1:0]   model_map_bits = ecb_pkg::MAP_INDEX_BITS_RST;
  logic [ecb_pkg::INDEX_W-1:0] last_edge_addr = '0;

  trace_event_t trace_events [$];
  hit_result_t  expected_hits [$];

  logic in_fire_seen = 1'b0;
  logic out_fire_seen = 1'b0;
  bit   idle_on = 1'b1;
  int   tx_wait = 0;
  int   rx_wait = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   cycle_count = 0;

  int   mismatches = 0;
  int   results_checked = 0;
  int   records_seen = 0;
  int   reads_seen = 0;
  int   wraps_seen = 0;
  int   settings_used = 0;

  function automatic logic [ecb_pkg::MIX_W-1:0] mix_location(
      logic [ecb_pkg::HASH_W-1:0] seed);
    logic [ecb_pkg::HASH_W-1:0] x;
    x = seed;
    x = x ^ (x >> 16);
    x = x * {32'd0, ecb_pkg::MIX_MUL_A};
    x = x ^ (x >> 15);
    x = x * {32'd0, ecb_pkg::MIX_MUL_B};
    x = x ^ (x >> 16);
    return x[ecb_pkg::MIX_W-1:0];
  endfunction

  function automatic logic [ecb_pkg::INDEX_W-1:0] active_mask();
    int unsigned bits;
    bits = model_map_bits;
    if (bits < 1) bits = 1;
    if (bits > MAP_BITS) bits = MAP_BITS;
    return ecb_pkg::INDEX_W'((32'd1 << bits) - 32'd1);
  endfunction

  // updates the predicted bitmap and returns the counter the block should report
  function automatic hit_result_t update_bitmap(trace_event_t ev);
    hit_result_t                 res;
    logic [ecb_pkg::INDEX_W-1:0] mask;
    logic [ecb_pkg::MIX_W-1:0]   loc;
    logic [ecb_pkg::INDEX_W-1:0] edge_addr;
    mask = active_mask();
    if (ev.opcode == ecb_pkg::OPC_READ) begin
      res.entry_index = ev.read_index & mask;
      res.hit_count   = model_counts[res.entry_index];
      reads_seen++;
    end else begin
      loc       = mix_location((ev.mod_hash << 1) ^ ev.block_offset) & {16'd0, mask};
      edge_addr = (loc[ecb_pkg::INDEX_W-1:0] ^ model_prev_loc) & mask;
      model_counts[edge_addr] = model_counts[edge_addr] + 1'b1;
      model_prev_loc  = ecb_pkg::INDEX_W'(loc >> 1);
      last_edge_addr  = edge_addr;
      res.entry_index = edge_addr;
      res.hit_count   = model_counts[edge_addr];
      if (res.hit_count == '0) wraps_seen++;
      records_seen++;
    end
    return res;
  endfunction

  function automatic int draw_wait();
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic trace_event_t make_event(logic opc, logic [ecb_pkg::HASH_W-1:0] mh,
                                              logic [ecb_pkg::HASH_W-1:0] off,
                                              logic [ecb_pkg::INDEX_W-1:0] idx,
                                              logic recent);
    trace_event_t ev;
    ev.opcode       = opc;
    ev.mod_hash     = mh;
    ev.block_offset = off;
    ev.read_index   = idx;
    ev.read_recent  = recent;
    return ev;
  endfunction

  function automatic trace_event_t random_event();
    trace_event_t ev;
    ev.opcode       = ($urandom_range(0, 99) < 30) ? ecb_pkg::OPC_READ : ecb_pkg::OPC_RECORD;
    ev.mod_hash     = {$urandom, $urandom};
    ev.block_offset = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       ev.read_index = '1;
      1:       ev.read_index = '0;
      default: ev.read_index = ecb_pkg::INDEX_W'($urandom);
    endcase
    ev.read_recent  = (ev.opcode == ecb_pkg::OPC_READ) && ($urandom_range(0, 1) == 1);
    return ev;
  endfunction

  // accept side: prediction and result checking
  always @(posedge clk) begin
    hit_result_t got;
    hit_result_t want;
    in_fire_seen  <= rst_n && in_valid && in_if.ready;
    out_fire_seen <= rst_n && out_if.valid && out_ready;
    if (rst_n && out_if.valid && out_ready) begin
      got.entry_index = out_if.entry_index;
      got.hit_count   = out_if.hit_count;
      results_checked++;
      if (expected_hits.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual index %h count %h",
                 $time, got.entry_index, got.hit_count);
      end else begin
        want = expected_hits.pop_front();
        if (got.entry_index !== want.entry_index) begin
          mismatches++;
          $display("%0t: entry_index mismatch, expected %h actual %h",
                   $time, want.entry_index, got.entry_index);
        end
        if (got.hit_count !== want.hit_count) begin
          mismatches++;
          $display("%0t: hit_count mismatch at index %h, expected %h actual %h",
                   $time, want.entry_index, want.hit_count, got.hit_count);
        end
      end
    end
    if (rst_n && in_valid && in_if.ready)
      expected_hits.push_back(update_bitmap(offered));
  end

  // trace event driver
  always @(negedge clk) begin
    logic next_valid;
    trace_event_t ev;
    if (rst_n) begin
      next_valid = in_valid;
      if (in_fire_seen) begin
        next_valid = 1'b0;
        tx_wait    = draw_wait();
      end
      if (!next_valid) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (trace_events.size() != 0) begin
          ev = trace_events.pop_front();
          if (ev.read_recent) ev.read_index = last_edge_addr;
          offered    = ev;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire_seen) begin
        rx_wait = draw_wait();
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // one long receiver hold-off so the core backs up into its input
  always @(negedge clk) begin
    if (!hold_done && results_checked == 30) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_hits.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic run_phase(input logic [ecb_pkg::CFG_W-1:0] bits, input int count,
                           input bit hot, input bit idle, input bit directed);
    trace_event_t               ev;
    logic [ecb_pkg::HASH_W-1:0] hot_hash;
    logic [ecb_pkg::HASH_W-1:0] hot_off;
    hot_hash = {$urandom, $urandom};
    hot_off  = {$urandom, $urandom};
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_bits  <= bits;
    do @(posedge clk); while (!cfg_if.ready);
    model_map_bits = bits;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    idle_on = idle;
    if (directed) begin
      trace_events.push_back(make_event(ecb_pkg::OPC_RECORD, '0, '0, '0, 1'b0));
      trace_events.push_back(make_event(ecb_pkg::OPC_RECORD, '0, '0, '0, 1'b0));
      trace_events.push_back(make_event(ecb_pkg::OPC_READ, '0, '0, '0, 1'b1));
      trace_events.push_back(make_event(ecb_pkg::OPC_RECORD, '1, '1, '1, 1'b0));
      trace_events.push_back(make_event(ecb_pkg::OPC_READ, '1, '1, '0, 1'b1));
      trace_events.push_back(make_event(ecb_pkg::OPC_RECORD, '1, '0, '0, 1'b0));
      trace_events.push_back(make_event(ecb_pkg::OPC_RECORD, '0, '1, '1, 1'b0));
      // top bit of the module hash falls out of the shift
      trace_events.push_back(make_event(ecb_pkg::OPC_RECORD, 64'h8000_0000_0000_0000,
                                        '0, '0, 1'b0));
      trace_events.push_back(make_event(ecb_pkg::OPC_RECORD, 64'h0000_0000_ffff_ffff,
                                        64'h1, '0, 1'b0));
      trace_events.push_back(make_event(ecb_pkg::OPC_READ, '0, '0, '0, 1'b0));
      trace_events.push_back(make_event(ecb_pkg::OPC_READ, '0, '0, '1, 1'b0));
      trace_events.push_back(make_event(ecb_pkg::OPC_READ, '0, '0, '0, 1'b1));
      trace_events.push_back(make_event(ecb_pkg::OPC_RECORD, '0, '0, '1, 1'b0));
      trace_events.push_back(make_event(ecb_pkg::OPC_READ, '1, '1, 16'h5a5a, 1'b0));
    end
    for (int n = 0; n < count; n++) begin
      ev = random_event();
      // hot mode hammers one location so its counter wraps
      if (hot && $urandom_range(0, 99) < 85) begin
        ev.opcode       = ecb_pkg::OPC_RECORD;
        ev.mod_hash     = hot_hash;
        ev.block_offset = hot_off;
        ev.read_recent  = 1'b0;
      end
      trace_events.push_back(ev);
    end
    do @(posedge clk); while (trace_events.size() != 0 || in_valid || expected_hits.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // map size changes keep the counters, so later phases read earlier hits
    run_phase(5'd16, 200, 1'b0, 1'b1, 1'b1);
    run_phase(5'd4,  360, 1'b1, 1'b1, 1'b0);
    run_phase(5'd1,  150, 1'b0, 1'b1, 1'b0);
    run_phase(5'd0,  100, 1'b0, 1'b1, 1'b0);
    run_phase(5'd31, 150, 1'b0, 1'b0, 1'b0);
    run_phase(5'd8,  200, 1'b0, 1'b1, 1'b0);
    run_phase(5'd17,  60, 1'b0, 1'b1, 1'b0);
    run_phase(5'd16, 100, 1'b0, 1'b0, 1'b0);
    $display("covered %0d record and %0d read transactions over %0d map size settings",
             records_seen, reads_seen, settings_used);
    $display("%0d results checked, %0d counter wraps, %0d mismatches",
             results_checked, wraps_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
